### sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants shared by the circular deque controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DATA_W     = 32;
  localparam int MODE_W     = 3;
  localparam int CAP_W      = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = 1'b0;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic                     accepted;
    logic                     is_empty;
    logic                     is_full;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
  } cdq_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } cdq_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } cdq_cmd_t;

  typedef struct packed {
    logic out_free;
  } cdq_sts_t;

endpackage

### sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer that takes one word, lets the datapath execute it and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cdq_sts_t sts,
  output cdq_cmd_t cmd
);

  cdq_state_t state_r;
  cdq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### sv/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Ring store, head and tail pointers, capacity register and result register
// of the circular deque.
// ----------------------------------------------------------------------------
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cdq_cmd_t         cmd,
  output cdq_sts_t         sts,
  input  cdq_in_t          in_data,
  input  logic             out_stall,
  output logic             out_valid,
  output cdq_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_cap,
  output logic [CAP_W-1:0] cap_r
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int RESET_SLOTS = (DEPTH < 1024) ? DEPTH : 1024;
  localparam logic [IDX_W-1:0] RESET_LAST = IDX_W'(RESET_SLOTS - 1);
  localparam logic [IDX_W-1:0] DEPTH_LAST = IDX_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  last_r;
  logic [IDX_W-1:0]  last_nxt;
  logic [IDX_W-1:0]  head_r;
  logic [IDX_W-1:0]  head_nxt;
  logic [IDX_W-1:0]  tail_r;
  logic [IDX_W-1:0]  tail_nxt;
  logic              empty_r;
  logic              empty_nxt;
  logic              ok_r;
  logic              ok_nxt;
  cdq_in_t           item_r;
  logic [DATA_W-1:0] rd_head_r;
  logic [DATA_W-1:0] rd_tail_r;
  logic              byp_head_r;
  logic              byp_tail_r;
  logic              out_valid_r;
  cdq_out_t          out_data_r;
  cdq_out_t          out_data_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              full_now;
  logic              is_push;
  logic              is_pop;
  logic [31:0]       cap_lim;

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [IDX_W-1:0] last);
    step_up = (idx == last) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] last);
    step_down = (idx == '0) ? last : idx - 1'b1;
  endfunction

  always_comb begin
    cap_lim = {{(32 - CAP_W){1'b0}}, cfg_cap} - 32'd1;
    if (cfg_cap == '0) begin
      last_nxt = '0;
    end else if ({{(32 - CAP_W){1'b0}}, cfg_cap} > 32'(DEPTH)) begin
      last_nxt = DEPTH_LAST;
    end else begin
      last_nxt = cap_lim[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      last_r <= RESET_LAST;
    end else if (cfg_we) begin
      cap_r  <= cfg_cap;
      last_r <= last_nxt;
    end
  end

  assign full_now = !empty_r && (step_up(tail_r, last_r) == head_r);
  assign is_push  = (item_r.mode == MODE_PUSH_FRONT) || (item_r.mode == MODE_PUSH_BACK);
  assign is_pop   = (item_r.mode == MODE_POP_FRONT) || (item_r.mode == MODE_POP_BACK);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    ok_nxt    = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    if (is_push && !full_now) begin
      ok_nxt = 1'b1;
      we     = 1'b1;
      if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
      end else if (item_r.mode == MODE_PUSH_FRONT) begin
        head_nxt = step_down(head_r, last_r);
        waddr    = head_nxt;
      end else begin
        tail_nxt = step_up(tail_r, last_r);
        waddr    = tail_nxt;
      end
    end else if (is_pop && !empty_r) begin
      ok_nxt = 1'b1;
      if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else if (item_r.mode == MODE_POP_FRONT) begin
        head_nxt = step_up(head_r, last_r);
      end else begin
        tail_nxt = step_down(tail_r, last_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cfg_we) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      ok_r       <= ok_nxt;
      byp_head_r <= we && (waddr == head_nxt);
      byp_tail_r <= we && (waddr == tail_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (we) begin
        mem[waddr] <= item_r.value;
      end
      rd_head_r <= mem[head_nxt];
      rd_tail_r <= mem[tail_nxt];
    end
  end

  always_comb begin
    out_data_nxt.accepted = ok_r;
    out_data_nxt.is_empty = empty_r;
    out_data_nxt.is_full  = full_now;
    if (empty_r) begin
      out_data_nxt.front_value = '1;
      out_data_nxt.rear_value  = '1;
    end else begin
      out_data_nxt.front_value = byp_head_r ? item_r.value : rd_head_r;
      out_data_nxt.rear_value  = byp_tail_r ? item_r.value : rd_tail_r;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit
// Bounded double-ended queue in a ring store with a programmable capacity.
// ----------------------------------------------------------------------------
// Accept loads a word, execute runs it and finish registers its result, waiting
// while the output stalls; these are the steps of the sequencer around the
// single-write ring store port, and a new word is taken only after finish.
// A waiting result does not block the next word until that word finishes.
// Reset: synchronous, active low; the queue is empty and capacity is 1024.
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cdq_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cdq_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cdq_cmd_t         cmd;
  cdq_sts_t         sts;
  logic             cfg_we;
  logic [CAP_W-1:0] cap_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY) ?
                  {{(CFG_DATA_W - CAP_W){1'b0}}, cap_r} : '0;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_cap   (pwdata[CAP_W-1:0]),
    .cap_r     (cap_r)
  );

endmodule

### sv/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
  import cdq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input cdq_out_t out_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("second word taken while the first is in flight");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("queue reported both empty and full");

  a_empty_peek: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |->
      ((out_data.front_value == -32'sd1) && (out_data.rear_value == -32'sd1)))
    else $error("empty queue peek did not read all ones");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);
